### src/hkc_pkg.sv
// Shared types, constants and jamo lookup functions for the Hangul two-set key composer.
// No dependencies; imported by every module of the block.
`default_nettype none

package hkc_pkg;

   localparam logic [15:0] SYL_BASE  = 16'hAC00;
   localparam logic [15:0] LEAD_BASE = 16'h1100;
   localparam logic [15:0] MED_BASE  = 16'h1161;
   localparam int          MED_COUNT = 21;
   localparam int          FIN_COUNT = 28;

   typedef enum logic [1:0] {
      CMD_KEY    = 2'd0,
      CMD_BACK   = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_CANCEL = 2'd3
   } hkc_cmd_type;

   typedef enum logic [2:0] {
      PH_EMPTY   = 3'd0,
      PH_INITIAL = 3'd1,
      PH_VOWEL   = 3'd2,
      PH_CVOWEL  = 3'd3,
      PH_FINAL   = 3'd4,
      PH_CFINAL  = 3'd5
   } hkc_phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] key_code;
   } hkc_req_type;

   typedef struct packed {
      logic        has_char;
      logic [15:0] char_code;
      logic [15:0] preview_code;
      logic        is_last;
   } hkc_rsp_type;

   typedef struct packed {
      logic [4:0] initial_index;
      logic [4:0] vowel_index;
      logic [4:0] second_vowel_index;
      logic [4:0] final_index;
      logic [4:0] second_final_index;
   } hkc_comp_type;

   typedef struct packed {
      hkc_phase_type phase;
      hkc_comp_type  comp;
   } hkc_state_type;

   // classified transaction held in the queue
   typedef struct packed {
      hkc_cmd_type command;
      logic [6:0]  key_code;
      logic [4:0]  lead_pos;
      logic [4:0]  med_pos;
      logic [4:0]  fin_pos;
   } hkc_item_type;

   // outcome of executing one transaction
   typedef struct packed {
      logic         emit_comp;
      hkc_comp_type comp;
      logic         emit_key;
      logic [6:0]   key_code;
      hkc_comp_type post;
   } hkc_exec_type;

   typedef struct packed {
      logic        two;
      hkc_rsp_type first;
      hkc_rsp_type second;
   } hkc_bundle_type;

   function automatic logic [4:0] lead_pos(input logic [6:0] key);
      logic [4:0] p;
      unique case (key)
         7'h72:   p = 5'd1;   // r
         7'h52:   p = 5'd2;   // R
         7'h73:   p = 5'd3;   // s
         7'h65:   p = 5'd4;   // e
         7'h45:   p = 5'd5;   // E
         7'h66:   p = 5'd6;   // f
         7'h61:   p = 5'd7;   // a
         7'h71:   p = 5'd8;   // q
         7'h51:   p = 5'd9;   // Q
         7'h74:   p = 5'd10;  // t
         7'h54:   p = 5'd11;  // T
         7'h64:   p = 5'd12;  // d
         7'h77:   p = 5'd13;  // w
         7'h57:   p = 5'd14;  // W
         7'h63:   p = 5'd15;  // c
         7'h7A:   p = 5'd16;  // z
         7'h78:   p = 5'd17;  // x
         7'h76:   p = 5'd18;  // v
         7'h67:   p = 5'd19;  // g
         default: p = 5'd0;
      endcase
      return p;
   endfunction

   function automatic logic [4:0] med_pos(input logic [6:0] key);
      logic [4:0] p;
      unique case (key)
         7'h6B:   p = 5'd1;   // k
         7'h6F:   p = 5'd2;   // o
         7'h69:   p = 5'd3;   // i
         7'h4F:   p = 5'd4;   // O
         7'h6A:   p = 5'd5;   // j
         7'h70:   p = 5'd6;   // p
         7'h75:   p = 5'd7;   // u
         7'h50:   p = 5'd8;   // P
         7'h68:   p = 5'd9;   // h
         7'h79:   p = 5'd13;  // y
         7'h6E:   p = 5'd14;  // n
         7'h62:   p = 5'd18;  // b
         7'h6D:   p = 5'd19;  // m
         7'h6C:   p = 5'd21;  // l
         default: p = 5'd0;
      endcase
      return p;
   endfunction

   function automatic logic [4:0] fin_pos(input logic [6:0] key);
      logic [4:0] p;
      unique case (key)
         7'h72:   p = 5'd1;   // r
         7'h52:   p = 5'd2;   // R
         7'h73:   p = 5'd4;   // s
         7'h65:   p = 5'd7;   // e
         7'h66:   p = 5'd8;   // f
         7'h61:   p = 5'd16;  // a
         7'h71:   p = 5'd17;  // q
         7'h74:   p = 5'd19;  // t
         7'h54:   p = 5'd20;  // T
         7'h64:   p = 5'd21;  // d
         7'h77:   p = 5'd22;  // w
         7'h63:   p = 5'd23;  // c
         7'h7A:   p = 5'd24;  // z
         7'h78:   p = 5'd25;  // x
         7'h76:   p = 5'd26;  // v
         7'h67:   p = 5'd27;  // g
         default: p = 5'd0;
      endcase
      return p;
   endfunction

   function automatic logic [4:0] med_pair(input logic [4:0] a, input logic [4:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (a == 5'd9 && b == 5'd1)   r = 5'd10;
      if (a == 5'd9 && b == 5'd2)   r = 5'd11;
      if (a == 5'd9 && b == 5'd21)  r = 5'd12;
      if (a == 5'd14 && b == 5'd5)  r = 5'd15;
      if (a == 5'd14 && b == 5'd6)  r = 5'd16;
      if (a == 5'd14 && b == 5'd21) r = 5'd17;
      if (a == 5'd19 && b == 5'd21) r = 5'd20;
      return r;
   endfunction

   function automatic logic [4:0] fin_pair(input logic [4:0] a, input logic [4:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (a == 5'd1 && b == 5'd19)  r = 5'd3;
      if (a == 5'd4 && b == 5'd22)  r = 5'd5;
      if (a == 5'd4 && b == 5'd27)  r = 5'd6;
      if (a == 5'd8 && b == 5'd1)   r = 5'd9;
      if (a == 5'd8 && b == 5'd16)  r = 5'd10;
      if (a == 5'd8 && b == 5'd17)  r = 5'd11;
      if (a == 5'd8 && b == 5'd19)  r = 5'd12;
      if (a == 5'd8 && b == 5'd25)  r = 5'd13;
      if (a == 5'd8 && b == 5'd26)  r = 5'd14;
      if (a == 5'd8 && b == 5'd27)  r = 5'd15;
      if (a == 5'd17 && b == 5'd19) r = 5'd18;
      return r;
   endfunction

   // final consonant re-read as the initial of the next syllable
   function automatic logic [4:0] fin_as_lead(input logic [4:0] f);
      logic [4:0] r;
      unique case (f)
         5'd1:    r = 5'd1;
         5'd2:    r = 5'd2;
         5'd4:    r = 5'd3;
         5'd7:    r = 5'd4;
         5'd8:    r = 5'd6;
         5'd16:   r = 5'd7;
         5'd17:   r = 5'd8;
         5'd19:   r = 5'd10;
         5'd20:   r = 5'd11;
         5'd21:   r = 5'd12;
         5'd22:   r = 5'd13;
         5'd23:   r = 5'd15;
         5'd24:   r = 5'd16;
         5'd25:   r = 5'd17;
         5'd26:   r = 5'd18;
         5'd27:   r = 5'd19;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic comp_empty(input hkc_comp_type c);
      return c.initial_index == 5'd0 && c.vowel_index == 5'd0 &&
             c.second_vowel_index == 5'd0 && c.final_index == 5'd0 &&
             c.second_final_index == 5'd0;
   endfunction

   function automatic logic [15:0] comp_code(input hkc_comp_type c);
      logic [4:0]  cv;
      logic [4:0]  cf;
      logic [15:0] i16;
      logic [15:0] cv16;
      logic [15:0] cf16;
      logic [15:0] r;
      cv = med_pair(c.vowel_index, c.second_vowel_index);
      if (cv == 5'd0) cv = c.vowel_index;
      cf = fin_pair(c.final_index, c.second_final_index);
      if (cf == 5'd0) cf = c.final_index;
      i16  = {11'd0, c.initial_index};
      cv16 = {11'd0, cv};
      cf16 = {11'd0, cf};
      if (c.initial_index != 5'd0 && c.vowel_index == 5'd0) begin
         r = LEAD_BASE + i16 - 16'd1;
      end else if (c.initial_index == 5'd0 && c.vowel_index != 5'd0) begin
         r = MED_BASE + cv16 - 16'd1;
      end else if (c.initial_index == 5'd0) begin
         r = 16'd0;
      end else begin
         r = SYL_BASE + (i16 - 16'd1) * 16'(MED_COUNT * FIN_COUNT)
             + (cv16 - 16'd1) * 16'(FIN_COUNT) + cf16;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/hangul_two_set_key_composer.sv
// Hangul two-set key composer, top level: classifier, transaction queue and
// execute/encode back end. Depends on hkc_pkg, hkc_front, hkc_queue, hkc_back.
//
// Keys of the Korean two-set layout are composed into Hangul syllables and given
// out as UCS-2 code units; other keys pass through after the pending syllable.
// Each transaction yields one result, or two when a syllable is completed by a
// key outside the layout; is_last marks the final one and every result carries
// the preview of the syllable still open. Results are handed out one per cycle
// while rsp_ready is high, both taken from the single result register. A
// transaction passes through the queue, the execute register and the encode
// register before its first result is valid. The queue of QUEUE_DEPTH
// entries lets the input keep accepting while results wait.
`default_nettype none

module hangul_two_set_key_composer
   import hkc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hkc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hkc_rsp_type rsp_data
);

   hkc_item_type front_item;
   hkc_item_type queue_item;
   logic         queue_valid;
   logic         back_ready;

   hkc_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   hkc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_item   (queue_item)
   );

   hkc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (back_ready),
      .item       (queue_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### src/hkc_front.sv
// Front end of the key composer: classifies an incoming transaction against the
// two-set layout tables. Depends on hkc_pkg.
`default_nettype none

module hkc_front
   import hkc_pkg::*;
(
   input  hkc_req_type  req_data,
   output hkc_item_type item
);

   always_comb begin
      item.command  = hkc_cmd_type'(req_data.command);
      item.key_code = req_data.key_code;
      item.lead_pos = lead_pos(req_data.key_code);
      item.med_pos  = med_pos(req_data.key_code);
      item.fin_pos  = fin_pos(req_data.key_code);
   end

endmodule

`default_nettype wire

### src/hkc_queue.sv
// Short queue of classified transactions between front and back end.
// Depends on hkc_pkg.
`default_nettype none

module hkc_queue
   import hkc_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  hkc_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output hkc_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hkc_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[head_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count not advanced on push");

endmodule

`default_nettype wire

### src/hkc_back.sv
// Back end of the key composer: executes queued transactions on the composition
// state, encodes the code units and hands out one or two results. Depends on hkc_pkg.
`default_nettype none

module hkc_back
   import hkc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   output logic         item_ready,
   input  hkc_item_type item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hkc_rsp_type  rsp_data
);

   hkc_state_type  st_ff, st_in;
   logic           x_valid_ff, x_valid_in;
   hkc_exec_type   x_ff, x_in;
   logic           e_valid_ff, e_valid_in;
   hkc_bundle_type e_ff, e_in;
   logic           sel_ff, sel_in;

   logic           last_out;
   logic           e_free;
   logic           take;
   logic           load_e;
   logic           start;
   logic           fall;
   logic           carry;
   hkc_comp_type   base;
   hkc_comp_type   cut;
   logic [4:0]     next_lead;
   logic [15:0]    preview;
   logic [15:0]    first_code;

   assign last_out   = !e_ff.two || sel_ff;
   assign e_free     = !e_valid_ff || (rsp_ready && last_out);
   assign item_ready = !x_valid_ff || e_free;
   assign take       = item_valid && item_ready;
   assign load_e     = x_valid_ff && e_free;
   assign rsp_valid  = e_valid_ff;
   assign rsp_data   = sel_ff ? e_ff.second : e_ff.first;

   // execute
   always_comb begin
      st_in          = st_ff;
      x_in           = '0;
      x_in.comp      = st_ff.comp;
      x_in.key_code  = item.key_code;
      base           = st_ff.comp;
      cut            = st_ff.comp;
      next_lead      = 5'd0;
      start          = 1'b0;
      fall           = 1'b0;
      carry          = 1'b0;
      unique case (item.command)
         CMD_KEY: begin
            unique case (st_ff.phase)
               PH_INITIAL: begin
                  if (item.med_pos != 5'd0) begin
                     st_in.comp.vowel_index = item.med_pos;
                     st_in.phase = PH_VOWEL;
                  end else begin
                     fall = 1'b1;
                  end
               end
               PH_VOWEL: begin
                  priority if (item.med_pos != 5'd0 &&
                               med_pair(st_ff.comp.vowel_index, item.med_pos) != 5'd0) begin
                     st_in.comp.second_vowel_index = item.med_pos;
                     st_in.phase = PH_CVOWEL;
                  end else if (item.fin_pos != 5'd0) begin
                     st_in.comp.final_index = item.fin_pos;
                     st_in.phase = PH_FINAL;
                  end else begin
                     fall = 1'b1;
                  end
               end
               PH_CVOWEL: begin
                  if (item.fin_pos != 5'd0) begin
                     st_in.comp.final_index = item.fin_pos;
                     st_in.phase = PH_FINAL;
                  end else begin
                     fall = 1'b1;
                  end
               end
               PH_FINAL: begin
                  priority if (item.fin_pos != 5'd0 &&
                               fin_pair(st_ff.comp.final_index, item.fin_pos) != 5'd0) begin
                     st_in.comp.second_final_index = item.fin_pos;
                     st_in.phase = PH_CFINAL;
                  end else if (item.med_pos != 5'd0) begin
                     carry = 1'b1;
                  end else begin
                     fall = 1'b1;
                  end
               end
               PH_CFINAL: begin
                  if (item.med_pos != 5'd0) begin
                     carry = 1'b1;
                  end else begin
                     fall = 1'b1;
                  end
               end
               default: begin
                  start = 1'b1;
               end
            endcase
         end
         CMD_BACK: begin
            priority if (st_ff.comp.second_final_index != 5'd0) begin
               st_in.comp.second_final_index = 5'd0;
               st_in.phase = PH_FINAL;
            end else if (st_ff.comp.final_index != 5'd0) begin
               st_in.comp.final_index = 5'd0;
               st_in.phase = (st_ff.comp.second_vowel_index != 5'd0) ? PH_CVOWEL : PH_VOWEL;
            end else if (st_ff.comp.second_vowel_index != 5'd0) begin
               st_in.comp.second_vowel_index = 5'd0;
               st_in.phase = PH_VOWEL;
            end else if (st_ff.comp.vowel_index != 5'd0) begin
               st_in.comp.vowel_index = 5'd0;
               st_in.phase = (st_ff.comp.initial_index != 5'd0) ? PH_INITIAL : PH_EMPTY;
            end else begin
               st_in.comp.initial_index = 5'd0;
               st_in.phase = PH_EMPTY;
            end
         end
         CMD_FLUSH: begin
            x_in.emit_comp = !comp_empty(st_ff.comp);
            st_in.comp     = '0;
            st_in.phase    = PH_EMPTY;
         end
         CMD_CANCEL: begin
            st_in.comp  = '0;
            st_in.phase = PH_EMPTY;
         end
         default: begin
            st_in = st_ff;
         end
      endcase

      // vowel after a final: the final opens the next syllable
      if (carry) begin
         priority if (st_ff.comp.second_final_index != 5'd0) begin
            next_lead = fin_as_lead(st_ff.comp.second_final_index);
            cut.second_final_index = 5'd0;
         end else if (st_ff.comp.final_index != 5'd0) begin
            next_lead = fin_as_lead(st_ff.comp.final_index);
            cut.final_index = 5'd0;
         end else begin
            next_lead = 5'd0;
         end
         x_in.emit_comp = 1'b1;
         x_in.comp      = cut;
         st_in.comp     = '0;
         st_in.comp.initial_index = next_lead;
         st_in.comp.vowel_index   = item.med_pos;
         st_in.phase    = PH_VOWEL;
      end

      if (fall) begin
         x_in.emit_comp = 1'b1;
         x_in.comp      = st_ff.comp;
         base           = '0;
         start          = 1'b1;
      end

      if (start) begin
         priority if (item.lead_pos != 5'd0) begin
            st_in.comp = base;
            st_in.comp.initial_index = item.lead_pos;
            st_in.phase = PH_INITIAL;
         end else if (item.med_pos != 5'd0) begin
            st_in.comp = base;
            st_in.comp.vowel_index = item.med_pos;
            st_in.phase = PH_VOWEL;
         end else begin
            if (!comp_empty(base)) begin
               x_in.emit_comp = 1'b1;
               x_in.comp      = base;
            end
            st_in.comp    = '0;
            st_in.phase   = PH_EMPTY;
            x_in.emit_key = 1'b1;
         end
      end

      x_in.post = st_in.comp;
   end

   // encode
   always_comb begin
      preview    = comp_empty(x_ff.post) ? 16'd0 : comp_code(x_ff.post);
      first_code = x_ff.emit_comp ? comp_code(x_ff.comp) :
                   (x_ff.emit_key ? {9'd0, x_ff.key_code} : 16'd0);
      e_in.two                 = x_ff.emit_comp && x_ff.emit_key;
      e_in.first.has_char      = x_ff.emit_comp || x_ff.emit_key;
      e_in.first.char_code     = first_code;
      e_in.first.preview_code  = preview;
      e_in.first.is_last       = !(x_ff.emit_comp && x_ff.emit_key);
      e_in.second.has_char     = 1'b1;
      e_in.second.char_code    = {9'd0, x_ff.key_code};
      e_in.second.preview_code = preview;
      e_in.second.is_last      = 1'b1;
   end

   always_comb begin
      x_valid_in = take ? 1'b1 : (load_e ? 1'b0 : x_valid_ff);
      e_valid_in = load_e ? 1'b1 : (e_free ? 1'b0 : e_valid_ff);
      sel_in     = sel_ff;
      if (load_e) begin
         sel_in = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         sel_in = !last_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= '{phase: PH_EMPTY, comp: '0};
         x_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         sel_ff     <= 1'b0;
      end else begin
         if (take) begin
            st_ff <= st_in;
         end
         x_valid_ff <= x_valid_in;
         e_valid_ff <= e_valid_in;
         sel_ff     <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_ff <= x_in;
      end
      if (load_e) begin
         e_ff <= e_in;
      end
   end

   a_sel_two: assert property (@(posedge clock) disable iff (reset)
      (e_valid_ff && sel_ff) |-> e_ff.two)
      else $error("second result selected for a single-result transaction");

   a_empty_phase: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_EMPTY) |-> comp_empty(st_ff.comp))
      else $error("empty phase with a composition held");

   a_cfinal: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_CFINAL) |-> (st_ff.comp.second_final_index != 5'd0 &&
                                      st_ff.comp.final_index != 5'd0))
      else $error("compound final phase without both finals");

   a_cvowel: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_CVOWEL) |-> (st_ff.comp.second_vowel_index != 5'd0 &&
                                      st_ff.comp.final_index == 5'd0))
      else $error("compound vowel phase inconsistent");

endmodule

`default_nettype wire
